>>> rtl/radar_line_occupancy_light_assert.svh
// Assertion macros shared by the radar line occupancy light RTL.
`ifndef RADAR_LINE_OCCUPANCY_LIGHT_ASSERT_SVH
`define RADAR_LINE_OCCUPANCY_LIGHT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ROL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ROL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

>>> rtl/rol_pkg.sv
// Package: types, codes and constants of the radar line occupancy light.
package rol_pkg;

    localparam int DISTANCE_BITS_DEF = 16;
    localparam int THR_BITS          = 16;
    localparam int TIME_BITS         = 24;
    localparam int BLINK_BITS        = 16;
    localparam int CFG_DATA_BITS     = 24;
    localparam int CFG_INDEX_BITS    = 3;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_POLL = 2'd1,
        OP_TICK = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        CLS_EMPTY  = 3'd0,
        CLS_PREFIX = 3'd1,
        CLS_NUMBER = 3'd2,
        CLS_BADNUM = 3'd3,
        CLS_OFF    = 3'd4,
        CLS_OTHER  = 3'd5
    } cls_t;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_DIST_OK = 3'd1,
        ST_BAD_NUM = 3'd2,
        ST_OFF     = 3'd3,
        ST_GPIO    = 3'd4
    } status_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RED_HOLD     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_YELLOW_UNTIL = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DATA_TIMEOUT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLINK_PERIOD = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLINK_ON     = 3'd5;

    // Reset values of the configuration registers
    localparam logic [THR_BITS-1:0]   RST_THRESHOLD    = 16'd100;
    localparam logic [TIME_BITS-1:0]  RST_RED_HOLD     = 24'd25000;
    localparam logic [TIME_BITS-1:0]  RST_YELLOW_UNTIL = 24'd30000;
    localparam logic [TIME_BITS-1:0]  RST_DATA_TIMEOUT = 24'd3000;
    localparam logic [BLINK_BITS-1:0] RST_BLINK_PERIOD = 16'd500;
    localparam logic [BLINK_BITS-1:0] RST_BLINK_ON     = 16'd250;

    // Characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Prefix positions
    localparam logic [3:0] DIST_KEY_LEN = 4'd9;
    localparam logic [3:0] OFF_KEY_LEN  = 4'd3;
    localparam logic [3:0] POS_DIGITS   = 4'd10;  // number has at least one digit or point

    typedef struct packed {
        logic [THR_BITS-1:0]   threshold;
        logic [TIME_BITS-1:0]  red_hold;
        logic [TIME_BITS-1:0]  yellow_until;
        logic [TIME_BITS-1:0]  data_timeout;
        logic [BLINK_BITS-1:0] blink_period;
        logic [BLINK_BITS-1:0] blink_on;
    } cfg_t;

    typedef struct packed {
        logic    line_end;
        logic    data_line;     // a non-empty line ended
        logic    absent_start;  // presence fell at this line end
        logic    presence;      // presence after this beat
        status_t status;
    } line_evt_t;

    typedef struct packed {
        logic red;
        logic yellow;
        logic green;
    } lights_t;

    // "distance:" by position
    function automatic logic [7:0] dist_key(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h64;  // d
            4'd1:    ch = 8'h69;  // i
            4'd2:    ch = 8'h73;  // s
            4'd3:    ch = 8'h74;  // t
            4'd4:    ch = 8'h61;  // a
            4'd5:    ch = 8'h6E;  // n
            4'd6:    ch = 8'h63;  // c
            4'd7:    ch = 8'h65;  // e
            4'd8:    ch = 8'h3A;  // :
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "OFF" by position
    function automatic logic [7:0] off_key(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h4F;  // O
            4'd1:    ch = 8'h46;  // F
            4'd2:    ch = 8'h46;  // F
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/radar_line_occupancy_light.sv
// An accepted input beat's result is registered and shows on the output in the next cycle.
// Throughput: one beat per cycle unless stalled; the parser and timer update in a
// single pass between the input handshake and the result register.
// Input stalls only while a result waits in the output register and the sink stalls.
// Reset (rst_n low, asynchronous): config registers take their defaults,
// line state, presence, distance and timers clear, no result is pending.
module radar_line_occupancy_light #(
    parameter int DISTANCE_BITS = rol_pkg::DISTANCE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [rol_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [rol_pkg::CFG_DATA_BITS-1:0]   cfg_data,

    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          operation,
    input  logic [7:0]                          byte_value,
    input  logic                                gpio_level,

    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                red_on,
    output logic                                yellow_on,
    output logic                                green_on,
    output logic                                present,
    output logic [DISTANCE_BITS-1:0]            distance_cm,
    output logic [2:0]                          line_status
);

`include "radar_line_occupancy_light_assert.svh"

    rol_pkg::cfg_t       cfg_reg;
    rol_pkg::line_evt_t  evt;
    rol_pkg::lights_t    lights;
    logic [DISTANCE_BITS-1:0] distance;
    logic                accept;
    logic                tick;

    // result register
    logic                     out_valid_reg, out_valid_next;
    rol_pkg::lights_t         lights_reg;
    logic                     present_reg;
    logic [DISTANCE_BITS-1:0] distance_reg;
    rol_pkg::status_t         status_reg;

    // A beat enters whenever the result slot is free or being drained this cycle.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign tick     = (operation == rol_pkg::OP_TICK);

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold    <= rol_pkg::RST_THRESHOLD;
            cfg_reg.red_hold     <= rol_pkg::RST_RED_HOLD;
            cfg_reg.yellow_until <= rol_pkg::RST_YELLOW_UNTIL;
            cfg_reg.data_timeout <= rol_pkg::RST_DATA_TIMEOUT;
            cfg_reg.blink_period <= rol_pkg::RST_BLINK_PERIOD;
            cfg_reg.blink_on     <= rol_pkg::RST_BLINK_ON;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                rol_pkg::CFG_THRESHOLD:
                    cfg_reg.threshold <= cfg_data[rol_pkg::THR_BITS-1:0];
                rol_pkg::CFG_RED_HOLD:
                    cfg_reg.red_hold <= cfg_data[rol_pkg::TIME_BITS-1:0];
                rol_pkg::CFG_YELLOW_UNTIL:
                    cfg_reg.yellow_until <= cfg_data[rol_pkg::TIME_BITS-1:0];
                rol_pkg::CFG_DATA_TIMEOUT:
                    cfg_reg.data_timeout <= cfg_data[rol_pkg::TIME_BITS-1:0];
                rol_pkg::CFG_BLINK_PERIOD:
                    cfg_reg.blink_period <= cfg_data[rol_pkg::BLINK_BITS-1:0];
                rol_pkg::CFG_BLINK_ON:
                    cfg_reg.blink_on <= cfg_data[rol_pkg::BLINK_BITS-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Byte gathering, line classification, presence and held distance.
    rol_parser #(
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .operation  (operation),
        .byte_value (byte_value),
        .gpio_level (gpio_level),
        .threshold  (cfg_reg.threshold),
        .evt        (evt),
        .distance   (distance)
    );

    // Millisecond timers and the light decision on the post-update state.
    rol_timer u_timer (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .tick   (tick),
        .evt    (evt),
        .cfg    (cfg_reg),
        .lights (lights)
    );

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // payload: loads with each accepted beat, holds while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lights_reg   <= lights;
            present_reg  <= evt.presence;
            distance_reg <= distance;
            status_reg   <= evt.status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_on      = lights_reg.red;
    assign yellow_on   = lights_reg.yellow;
    assign green_on    = lights_reg.green;
    assign present     = present_reg;
    assign distance_cm = distance_reg;
    assign line_status = status_reg;

    // every accepted beat shows up in the result register next cycle
    `ROL_ASSERT_NEXT(a_accept_result, clk, rst_n, accept, out_valid_reg)
    // at most one light is driven
    `ROL_ASSERT_NOW(a_one_light, clk, rst_n, out_valid_reg,
                    $onehot0({lights_reg.red, lights_reg.yellow, lights_reg.green}))
    // green never shows while someone is present
    `ROL_ASSERT_NOW(a_no_green_present, clk, rst_n, out_valid_reg && present_reg,
                    !lights_reg.green)

endmodule

>>> rtl/rol_parser.sv
// Line parser: gathers radar bytes, classifies the line, holds presence and distance.
module rol_parser #(
    parameter int DISTANCE_BITS = rol_pkg::DISTANCE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [1:0]                    operation,
    input  logic [7:0]                    byte_value,
    input  logic                          gpio_level,
    input  logic [rol_pkg::THR_BITS-1:0]  threshold,
    output rol_pkg::line_evt_t            evt,
    output logic [DISTANCE_BITS-1:0]      distance
);

`include "radar_line_occupancy_light_assert.svh"

    localparam int NUM_BITS  = ((DISTANCE_BITS > 16) ? DISTANCE_BITS : 16) + 1;
    localparam int PROD_BITS = NUM_BITS + 4;
    localparam logic [PROD_BITS-1:0] NUM_CAP  = PROD_BITS'(1) << (NUM_BITS - 1);
    localparam logic [NUM_BITS-1:0]  DIST_MAX = (NUM_BITS'(1) << DISTANCE_BITS) - NUM_BITS'(1);

    rol_pkg::cls_t              cls_reg, cls_next;
    logic [3:0]                 pos_reg, pos_next;
    logic                       point_reg, point_next;
    logic                       frac_reg, frac_next;
    logic [NUM_BITS-1:0]        num_reg, num_next;
    logic                       presence_reg, presence_next;
    logic [DISTANCE_BITS-1:0]   held_reg, held_next;

    logic [PROD_BITS-1:0]       prod;
    logic [NUM_BITS-1:0]        num_sat;
    logic [NUM_BITS-1:0]        thr_ext;
    logic                       ends_line;
    logic                       take;
    logic                       is_digit;

    always_comb
    begin
        prod = ({4'b0, num_reg} << 3) + ({4'b0, num_reg} << 1)
             + PROD_BITS'(byte_value[3:0]);
        num_sat = (prod > NUM_CAP) ? NUM_CAP[NUM_BITS-1:0] : prod[NUM_BITS-1:0];
        thr_ext = NUM_BITS'(threshold);
        is_digit = byte_value inside {[rol_pkg::CH_ZERO:rol_pkg::CH_NINE]};
        ends_line = (operation == rol_pkg::OP_POLL)
                 || ((operation == rol_pkg::OP_BYTE) && (byte_value == rol_pkg::CH_LF));
        take = (operation == rol_pkg::OP_BYTE)
            && !(byte_value inside {rol_pkg::CH_LF, rol_pkg::CH_SPACE,
                                    rol_pkg::CH_CR, rol_pkg::CH_TAB});

        cls_next      = cls_reg;
        pos_next      = pos_reg;
        point_next    = point_reg;
        frac_next     = frac_reg;
        num_next      = num_reg;
        presence_next = presence_reg;
        held_next     = held_reg;
        evt           = '0;
        evt.status    = rol_pkg::ST_NONE;

        if (take)
        begin
            case (cls_reg)
                rol_pkg::CLS_EMPTY:
                begin
                    pos_next = 4'd1;
                    if (byte_value == rol_pkg::dist_key(4'd0))
                        cls_next = rol_pkg::CLS_PREFIX;
                    else if (byte_value == rol_pkg::off_key(4'd0))
                        cls_next = rol_pkg::CLS_OFF;
                    else
                    begin
                        cls_next = rol_pkg::CLS_OTHER;
                        pos_next = pos_reg;
                    end
                end
                rol_pkg::CLS_PREFIX:
                begin
                    if (pos_reg < rol_pkg::DIST_KEY_LEN
                        && byte_value == rol_pkg::dist_key(pos_reg))
                    begin
                        pos_next = pos_reg + 4'd1;
                        if (pos_next == rol_pkg::DIST_KEY_LEN)
                            cls_next = rol_pkg::CLS_NUMBER;
                    end
                    else
                        cls_next = rol_pkg::CLS_OTHER;
                end
                rol_pkg::CLS_NUMBER:
                begin
                    if (is_digit)
                    begin
                        pos_next = rol_pkg::POS_DIGITS;
                        if (!point_reg)
                            num_next = num_sat;
                        else if (byte_value != rol_pkg::CH_ZERO)
                            frac_next = 1'b1;
                    end
                    else if (byte_value == rol_pkg::CH_POINT && !point_reg)
                    begin
                        pos_next   = rol_pkg::POS_DIGITS;
                        point_next = 1'b1;
                    end
                    else
                        cls_next = rol_pkg::CLS_BADNUM;
                end
                rol_pkg::CLS_OFF:
                begin
                    if (pos_reg < rol_pkg::OFF_KEY_LEN
                        && byte_value == rol_pkg::off_key(pos_reg))
                        pos_next = pos_reg + 4'd1;
                    else
                        cls_next = rol_pkg::CLS_OTHER;
                end
                default:
                begin
                    cls_next = cls_reg;  // bad number and other lines absorb bytes
                end
            endcase
        end

        if (ends_line)
        begin
            evt.line_end  = 1'b1;
            evt.data_line = (cls_reg != rol_pkg::CLS_EMPTY);
            if (cls_reg == rol_pkg::CLS_NUMBER && pos_reg == rol_pkg::POS_DIGITS)
            begin
                held_next = (num_reg > DIST_MAX) ? DIST_MAX[DISTANCE_BITS-1:0]
                                                 : num_reg[DISTANCE_BITS-1:0];
                presence_next = (num_reg < thr_ext) || (num_reg == thr_ext && !frac_reg);
                evt.status = rol_pkg::ST_DIST_OK;
            end
            else if (cls_reg == rol_pkg::CLS_NUMBER || cls_reg == rol_pkg::CLS_BADNUM)
                evt.status = rol_pkg::ST_BAD_NUM;
            else if (cls_reg == rol_pkg::CLS_OFF && pos_reg == rol_pkg::OFF_KEY_LEN)
            begin
                presence_next = 1'b0;
                held_next     = '0;
                evt.status    = rol_pkg::ST_OFF;
            end
            else
            begin
                presence_next = gpio_level;
                evt.status    = rol_pkg::ST_GPIO;
            end
            evt.absent_start = presence_reg && !presence_next;
            cls_next   = rol_pkg::CLS_EMPTY;
            pos_next   = '0;
            point_next = 1'b0;
            frac_next  = 1'b0;
            num_next   = '0;
        end

        evt.presence = presence_next;
        distance     = held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_reg      <= rol_pkg::CLS_EMPTY;
            pos_reg      <= '0;
            point_reg    <= 1'b0;
            frac_reg     <= 1'b0;
            num_reg      <= '0;
            presence_reg <= 1'b0;
            held_reg     <= '0;
        end
        else if (accept)
        begin
            cls_reg      <= cls_next;
            pos_reg      <= pos_next;
            point_reg    <= point_next;
            frac_reg     <= frac_next;
            num_reg      <= num_next;
            presence_reg <= presence_next;
            held_reg     <= held_next;
        end
    end

    // a number line has always seen the full prefix
    `ROL_ASSERT_NOW(a_number_prefix, clk, rst_n, cls_reg == rol_pkg::CLS_NUMBER,
                    pos_reg == rol_pkg::DIST_KEY_LEN || pos_reg == rol_pkg::POS_DIGITS)
    // OFF line drops presence and distance
    `ROL_ASSERT_NEXT(a_off_clears, clk, rst_n, accept && evt.status == rol_pkg::ST_OFF,
                     !presence_reg && held_reg == '0)

endmodule

>>> rtl/rol_timer.sv
// Empty-time and data-silence timers, blink phase and light decision.
module rol_timer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               tick,
    input  rol_pkg::line_evt_t evt,
    input  rol_pkg::cfg_t      cfg,
    output rol_pkg::lights_t   lights
);

`include "radar_line_occupancy_light_assert.svh"

    localparam int TB = rol_pkg::TIME_BITS;
    localparam int BB = rol_pkg::BLINK_BITS;

    logic [BB-1:0] phase_reg, phase_next;
    logic [TB-1:0] absent_reg, absent_next;
    logic [TB-1:0] since_reg, since_next;
    logic [BB-1:0] period;
    logic [BB:0]   phase_inc;

    always_comb
    begin
        period    = (cfg.blink_period == '0) ? BB'(1) : cfg.blink_period;
        phase_inc = {1'b0, phase_reg} + (BB + 1)'(1);

        phase_next  = phase_reg;
        absent_next = absent_reg;
        since_next  = since_reg;

        if (tick)
        begin
            phase_next = (phase_inc >= {1'b0, period}) ? '0 : phase_inc[BB-1:0];
            if (absent_reg != '1)
                absent_next = absent_reg + TB'(1);
            if (since_reg != '1)
                since_next = since_reg + TB'(1);
        end
        if (evt.absent_start)
            absent_next = '0;
        if (evt.data_line)
            since_next = '0;

        lights = '0;
        if (since_next > cfg.data_timeout)
            lights.yellow = (phase_next < cfg.blink_on);
        else if (evt.presence || absent_next < cfg.red_hold)
            lights.red = 1'b1;
        else if (absent_next <= cfg.yellow_until)
            lights.yellow = 1'b1;
        else
            lights.green = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            absent_reg <= '0;
            since_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            absent_reg <= absent_next;
            since_reg  <= since_next;
        end
    end

    // a non-empty line restarts the silence timer
    `ROL_ASSERT_NEXT(a_since_restart, clk, rst_n, accept && evt.data_line, since_reg == '0)

endmodule

>>> tb/tb.sv
// Self-checking bench for the radar line parser and occupancy light block.
`timescale 1ns / 100ps

module tb;
    import rol_pkg::*;

    // One result beat: light drives, presence, held distance and line verdict.
    typedef struct packed {
        logic        red;
        logic        yellow;
        logic        green;
        logic        present;
        logic [15:0] distance;
        status_t     status;
    } lamp_beat_t;

    // One row of the directed table; rows with typed set carry a hand-worked result.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       gpio;
        logic       typed;
        lamp_beat_t want;
    } drill_row_t;

    localparam logic [1:0]  OP_UNUSED   = 2'd3;    // no name in the package, block ignores it
    localparam int          DIGIT_CAP   = 65536;   // integer part saturates here
    localparam int          HOLD_CYCLES = 80;      // long sink hold-off
    localparam int          LIMIT       = 2000;    // cycles without any handshake
    localparam lamp_beat_t  NO_WANT     = '0;

    localparam logic [7:0] DIST_WORD [9] = '{"d", "i", "s", "t", "a", "n", "c", "e", ":"};
    localparam logic [7:0] OFF_WORD  [3] = '{"O", "F", "F"};

    // Directed opening, run with the reset register values. Lights stay red here:
    // the space has been empty for only a few ticks and data is fresh.
    localparam drill_row_t DRILL [24] = '{
        '{OP_TICK,   8'h00,    1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 16'd0, ST_NONE}},
        '{OP_UNUSED, 8'hFF,    1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 16'd0, ST_NONE}},
        // poll on an empty line: gpio fallback, presence follows the pin
        '{OP_POLL,   8'h00,    1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 16'd0, ST_GPIO}},
        // "O F<tick>F" with a blank and a tick inside, then newline
        '{OP_BYTE,   "O",      1'b0, 1'b0, NO_WANT},
        '{OP_BYTE,   "F",      1'b1, 1'b0, NO_WANT},
        '{OP_BYTE,   CH_SPACE, 1'b0, 1'b0, NO_WANT},
        '{OP_TICK,   8'h00,    1'b1, 1'b0, NO_WANT},
        '{OP_BYTE,   "F",      1'b0, 1'b0, NO_WANT},
        '{OP_BYTE,   CH_LF,    1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 16'd0, ST_OFF}},
        // prefix with no number behind it
        '{OP_BYTE,   "d",      1'b0, 1'b0, NO_WANT},
        '{OP_BYTE,   "i",      1'b0, 1'b0, NO_WANT},
        '{OP_BYTE,   "s",      1'b0, 1'b0, NO_WANT},
        '{OP_BYTE,   "t",      1'b0, 1'b0, NO_WANT},
        '{OP_BYTE,   "a",      1'b0, 1'b0, NO_WANT},
        '{OP_BYTE,   "n",      1'b0, 1'b0, NO_WANT},
        '{OP_BYTE,   "c",      1'b0, 1'b0, NO_WANT},
        '{OP_BYTE,   "e",      1'b0, 1'b0, NO_WANT},
        '{OP_BYTE,   ":",      1'b0, 1'b0, NO_WANT},
        '{OP_POLL,   8'h00,    1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 16'd0, ST_BAD_NUM}},
        // unknown first byte, tab dropped
        '{OP_BYTE,   8'hFF,    1'b1, 1'b0, NO_WANT},
        '{OP_BYTE,   CH_TAB,   1'b1, 1'b0, NO_WANT},
        '{OP_BYTE,   CH_LF,    1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 16'd0, ST_GPIO}},
        // blank-only line ended by newline
        '{OP_BYTE,   CH_CR,    1'b0, 1'b0, NO_WANT},
        '{OP_BYTE,   CH_LF,    1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 16'd0, ST_GPIO}}
    };

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        cfg_wr_en  = 1'b0;
    logic [2:0]  cfg_index  = CFG_THRESHOLD;
    logic [23:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  operation  = OP_BYTE;
    logic [7:0]  byte_value = '0;
    logic        gpio_level = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic        red_on;
    logic        yellow_on;
    logic        green_on;
    logic        present;
    logic [15:0] distance_cm;
    logic [2:0]  line_status;

    // Predicted state of the block
    cfg_t        regs;
    logic [15:0] blink_ms;
    logic [23:0] empty_ms;      // time since the space went empty
    logic [23:0] quiet_ms;      // time since the last non-empty line
    logic        occupied;
    logic [15:0] dist_hold;
    logic [3:0]  key_pos;
    cls_t        kind;
    logic        has_point;
    logic        frac_nz;
    logic [16:0] digits_val;

    lamp_beat_t  lamp_q [$];    // predicted result beats, oldest first
    int          mismatches   = 0;
    int          beats_sent   = 0;
    int          still_cycles = 0;
    bit          calm         = 1'b0;   // no idling on either side
    bit          hold_off_req = 1'b0;   // ask the sink for one long hold-off

    radar_line_occupancy_light dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .byte_value  (byte_value),
        .gpio_level  (gpio_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_on      (red_on),
        .yellow_on   (yellow_on),
        .green_on    (green_on),
        .present     (present),
        .distance_cm (distance_cm),
        .line_status (line_status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Line end: classify what was gathered, update presence and distance, clear the line.
    function automatic status_t finish_line(input logic g);
        status_t st;
        logic    was;
        was = occupied;
        if (kind == CLS_NUMBER && key_pos == POS_DIGITS)
        begin
            dist_hold = (digits_val > 17'd65535) ? 16'hFFFF : digits_val[15:0];
            occupied  = (digits_val < {1'b0, regs.threshold}) ||
                        (digits_val == {1'b0, regs.threshold} && !frac_nz);
            st = ST_DIST_OK;
        end
        else if (kind == CLS_NUMBER || kind == CLS_BADNUM)
            st = ST_BAD_NUM;
        else if (kind == CLS_OFF && key_pos == OFF_KEY_LEN)
        begin
            occupied  = 1'b0;
            dist_hold = '0;
            st = ST_OFF;
        end
        else
        begin
            occupied = g;
            st = ST_GPIO;
        end
        if (kind != CLS_EMPTY)
            quiet_ms = '0;
        if (was && !occupied)
            empty_ms = '0;
        kind       = CLS_EMPTY;
        key_pos    = '0;
        has_point  = 1'b0;
        digits_val = '0;
        frac_nz    = 1'b0;
        return st;
    endfunction

    // Advance the predicted state by one input beat and return the result beat it yields.
    function automatic lamp_beat_t predict_lamps(input logic [1:0] op, input logic [7:0] b,
                                                 input logic g);
        lamp_beat_t  r;
        int          period;
        logic [20:0] grown;
        r = NO_WANT;
        r.status = ST_NONE;
        if (op == OP_BYTE)
        begin
            if (b == CH_LF)
                r.status = finish_line(g);
            else if (b != CH_SPACE && b != CH_CR && b != CH_TAB)
            begin
                case (kind)
                    CLS_EMPTY:
                        if (b == DIST_WORD[0])
                        begin
                            kind = CLS_PREFIX;
                            key_pos = 4'd1;
                        end
                        else if (b == OFF_WORD[0])
                        begin
                            kind = CLS_OFF;
                            key_pos = 4'd1;
                        end
                        else
                            kind = CLS_OTHER;
                    CLS_PREFIX:
                        if (key_pos < DIST_KEY_LEN && b == DIST_WORD[key_pos])
                        begin
                            key_pos = key_pos + 4'd1;
                            if (key_pos == DIST_KEY_LEN)
                                kind = CLS_NUMBER;
                        end
                        else
                            kind = CLS_OTHER;
                    CLS_NUMBER:
                        if (b >= CH_ZERO && b <= CH_NINE)
                        begin
                            key_pos = POS_DIGITS;
                            if (!has_point)
                            begin
                                grown = 21'(digits_val) * 21'd10 + 21'(b - CH_ZERO);
                                digits_val = (grown > 21'(DIGIT_CAP)) ? 17'(DIGIT_CAP)
                                                                      : grown[16:0];
                            end
                            else if (b != CH_ZERO)
                                frac_nz = 1'b1;
                        end
                        else if (b == CH_POINT && !has_point)
                        begin
                            key_pos = POS_DIGITS;
                            has_point = 1'b1;
                        end
                        else
                            kind = CLS_BADNUM;
                    CLS_OFF:
                        if (key_pos < OFF_KEY_LEN && b == OFF_WORD[key_pos])
                            key_pos = key_pos + 4'd1;
                        else
                            kind = CLS_OTHER;
                    default: ;
                endcase
            end
        end
        else if (op == OP_POLL)
            r.status = finish_line(g);
        else if (op == OP_TICK)
        begin
            // a zero period acts as one; a phase past a shrunken period wraps
            period = (regs.blink_period == '0) ? 1 : int'(regs.blink_period);
            blink_ms = (int'(blink_ms) + 1 >= period) ? 16'd0 : blink_ms + 16'd1;
            if (empty_ms != 24'hFFFFFF)
                empty_ms = empty_ms + 24'd1;
            if (quiet_ms != 24'hFFFFFF)
                quiet_ms = quiet_ms + 24'd1;
        end

        // lights always follow the state after this beat
        if (quiet_ms > regs.data_timeout)
            r.yellow = (blink_ms < regs.blink_on);
        else if (occupied || empty_ms < regs.red_hold)
            r.red = 1'b1;
        else if (empty_ms <= regs.yellow_until)
            r.yellow = 1'b1;
        else
            r.green = 1'b1;
        r.present  = occupied;
        r.distance = dist_hold;
        return r;
    endfunction

    // Offer one input beat, wait for its acceptance and record the predicted result.
    // Valid stays high after acceptance; the next call or the caller lowers it.
    task automatic send_beat(input logic [1:0] op, input logic [7:0] data, input logic g);
        if (!calm && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 40)
                @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        byte_value <= data;
        gpio_level <= g;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        lamp_q.push_back(predict_lamps(op, data, g));
        beats_sent++;
    endtask

    // Send the characters of a line body, sprinkled with blanks, ticks and unused ops.
    task automatic send_text(input string text);
        for (int k = 0; k < text.len(); k++)
        begin
            if ($urandom_range(99) < 8)
                send_beat(OP_BYTE, ($urandom_range(2) == 0) ? CH_TAB :
                                   (($urandom_range(1) == 0) ? CH_SPACE : CH_CR),
                          1'($urandom));
            if ($urandom_range(99) < 4)
                send_beat(OP_TICK, 8'($urandom), 1'($urandom));
            if ($urandom_range(199) == 0)
                send_beat(OP_UNUSED, 8'($urandom), 1'($urandom));
            send_beat(OP_BYTE, text[k], 1'($urandom));
        end
    endtask

    // Register write; the predicted copy takes the same masked value.
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_THRESHOLD:    regs.threshold    = value[15:0];
            CFG_RED_HOLD:     regs.red_hold     = value;
            CFG_YELLOW_UNTIL: regs.yellow_until = value;
            CFG_DATA_TIMEOUT: regs.data_timeout = value;
            CFG_BLINK_PERIOD: regs.blink_period = value[15:0];
            CFG_BLINK_ON:     regs.blink_on     = value[15:0];
            default: ;
        endcase
    endtask

    task automatic report(input string field, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    // Result checker: every accepted result beat against the oldest prediction.
    always @(posedge clk)
    begin
        lamp_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (lamp_q.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, status %0d",
                         $time, line_status);
                mismatches++;
            end
            else
            begin
                want = lamp_q.pop_front();
                if (red_on !== want.red)
                    report("red_on", want.red, red_on);
                if (yellow_on !== want.yellow)
                    report("yellow_on", want.yellow, yellow_on);
                if (green_on !== want.green)
                    report("green_on", want.green, green_on);
                if (present !== want.present)
                    report("present", want.present, present);
                if (distance_cm !== want.distance)
                    report("distance_cm", want.distance, distance_cm);
                if (line_status !== want.status)
                    report("line_status", want.status, line_status);
            end
        end
    end

    // Sink: random stalls, none while calm, and one long hold-off on request so the
    // output register fills and the block stalls its input.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= !calm && ($urandom_range(99) < 23);
        end
    end

    // Watchdog: too long without any beat moving on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            still_cycles <= 0;
        else
            still_cycles <= still_cycles + 1;
        if (still_cycles == LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Stimulus: reset, directed table, then seven register settings with random lines.
    initial
    begin
        string       text;
        int          phase_end;
        int          pick;
        logic [15:0] thr_v;
        logic [15:0] per_v;
        logic [15:0] lit_v;
        logic [23:0] red_v;
        logic [23:0] yel_v;
        logic [23:0] tmo_v;

        regs.threshold    = RST_THRESHOLD;
        regs.red_hold     = RST_RED_HOLD;
        regs.yellow_until = RST_YELLOW_UNTIL;
        regs.data_timeout = RST_DATA_TIMEOUT;
        regs.blink_period = RST_BLINK_PERIOD;
        regs.blink_on     = RST_BLINK_ON;
        blink_ms   = '0;
        empty_ms   = '0;
        quiet_ms   = '0;
        occupied   = 1'b0;
        dist_hold  = '0;
        key_pos    = '0;
        kind       = CLS_EMPTY;
        has_point  = 1'b0;
        frac_nz    = 1'b0;
        digits_val = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Typed rows replace the prediction with the hand-worked beat.
        foreach (DRILL[k])
        begin
            send_beat(DRILL[k].op, DRILL[k].data, DRILL[k].gpio);
            if (DRILL[k].typed)
                lamp_q[lamp_q.size() - 1] = DRILL[k].want;
        end

        for (int p = 0; p < 7; p++)
        begin
            if (p > 0)
            begin
                // drain before touching the registers
                in_valid <= 1'b0;
                while (lamp_q.size() != 0)
                    @(posedge clk);
                @(posedge clk);
                case (p)
                    2:
                    begin
                        thr_v = 16'hFFFF;   red_v = 24'hFFFFFF; yel_v = 24'hFFFFFF;
                        tmo_v = 24'hFFFFFF; per_v = 16'hFFFF;   lit_v = 16'hFFFF;
                    end
                    3:
                    begin
                        thr_v = '0; red_v = '0; yel_v = '0;
                        tmo_v = '0; per_v = '0; lit_v = '0;
                    end
                    default:
                    begin
                        // short times so every light and the blink show up
                        thr_v = 16'($urandom_range(0, 400));
                        red_v = 24'($urandom_range(0, 40));
                        yel_v = 24'($urandom_range(0, 70));
                        tmo_v = 24'($urandom_range(0, 60));
                        per_v = 16'($urandom_range(0, 9));
                        lit_v = 16'($urandom_range(0, 10));
                    end
                endcase
                // upper bits of the 16-bit registers carry junk that must be ignored
                write_reg(CFG_THRESHOLD,    {8'($urandom), thr_v});
                write_reg(CFG_RED_HOLD,     red_v);
                write_reg(CFG_YELLOW_UNTIL, yel_v);
                write_reg(CFG_DATA_TIMEOUT, tmo_v);
                write_reg(CFG_BLINK_PERIOD, {8'($urandom), per_v});
                write_reg(CFG_BLINK_ON,     {8'($urandom), lit_v});
                cfg_wr_en <= 1'b0;
            end
            calm = (p == 5);
            if (p == 4)
                hold_off_req = 1'b1;

            // the last line of a phase runs past the mark by several beats
            phase_end = beats_sent + 52;
            while (beats_sent < phase_end)
            begin
                pick = $urandom_range(99);
                if (pick < 25)
                    repeat ($urandom_range(1, 24)) send_beat(OP_TICK, 8'($urandom), 1'($urandom));
                else
                begin
                    if (pick < 65)
                    begin
                        text = "distance:";
                        case ($urandom_range(7))
                            0: ;    // prefix and nothing else
                            1:
                            begin
                                text = {text, "."};
                                if ($urandom_range(1))
                                    text = {text, $sformatf("%0d", $urandom_range(0, 9))};
                            end
                            2:  // integer part on the threshold, fraction zero or not
                                text = {text, $sformatf("%0d.%0d", regs.threshold,
                                                        $urandom_range(0, 9))};
                            3:
                                text = {text, $sformatf("%0d", $urandom_range(65530, 65540))};
                            4:  // far past the cap
                                text = {text, $sformatf("%0d%0d", $urandom,
                                                        $urandom_range(0, 999))};
                            5:
                            begin
                                text = {text, $sformatf("%0d", $urandom_range(0, 500))};
                                if ($urandom_range(1))
                                    text = {text, ".5."};
                                else
                                    text = {text, "-"};
                            end
                            default:
                            begin
                                text = {text, $sformatf("%0d", $urandom_range(0,
                                                        2 * int'(regs.threshold) + 20))};
                                if ($urandom_range(1))
                                    text = {text, $sformatf(".%0d", $urandom_range(0, 99))};
                            end
                        endcase
                        // now and then a broken prefix
                        if ($urandom_range(99) < 8)
                            text[$urandom_range(8)] = 8'($urandom_range(33, 126));
                        send_text(text);
                    end
                    else if (pick < 77)
                    begin
                        case ($urandom_range(5))
                            3:       send_text("OF");
                            4:       send_text("OFFF");
                            5:       send_text("OFx");
                            default: send_text("OFF");
                        endcase
                    end
                    else if (pick < 89)
                        repeat ($urandom_range(1, 4))
                            send_beat(OP_BYTE, 8'($urandom), 1'($urandom));
                    else if ($urandom_range(1))
                        send_text(" \t");

                    // line end by newline or by poll
                    if ($urandom_range(2) == 0)
                        send_beat(OP_POLL, 8'($urandom), 1'($urandom));
                    else
                        send_beat(OP_BYTE, CH_LF, 1'($urandom));
                end
            end
        end

        in_valid <= 1'b0;
        while (lamp_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        if (mismatches == 0 && lamp_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
